// File: hdl/rle_pkg.sv
package rle_pkg;

  typedef struct packed {
    logic signed [15:0] ref_sample;
    logic signed [15:0] test_sample;
    logic               last_sample;
  } rle_in_t;

  typedef struct packed {
    logic [25:0] l2_ref;
    logic [25:0] l2_test;
    logic [25:0] l2_delta;
    logic [35:0] l1_ref;
    logic [35:0] l1_test;
    logic [35:0] l1_delta;
    logic [23:0] l2_relative;
    logic [23:0] l1_relative;
    logic        reference_zero;
    logic        count_overflow;
  } rle_out_t;

  localparam int unsigned SqRefW   = 51;
  localparam int unsigned SqDeltaW = 52;
  localparam int unsigned AbsW     = 36;
  localparam int unsigned RootW    = 26;
  localparam int unsigned RelW     = 24;
  localparam int unsigned QuotW    = 52;
  localparam int unsigned NumW     = 52;

  typedef enum logic [1:0] {
    CMD_IDLE,
    CMD_ACCUM,
    CMD_ROOT_START,
    CMD_DIV_START
  } rle_cmd_e;

  typedef struct packed {
    logic root_done;
    logic div_done;
  } rle_status_t;

endpackage

// File: hdl/rle_datapath.sv
module rle_datapath
  import rle_pkg::*;
#(
  parameter int unsigned COUNT_MAX   = 1048576,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rle_cmd_e    cmd_i,
  input  rle_in_t     in_i,
  output rle_status_t status_o,
  output rle_out_t    result_o
);

  localparam int unsigned CntW = $clog2(COUNT_MAX + 1);

  logic [SqRefW-1:0]   sq_ref_q, sq_test_q;
  logic [SqDeltaW-1:0] sq_delta_q;
  logic [AbsW-1:0]     ab_ref_q, ab_test_q, ab_delta_q;
  logic [CntW-1:0]     cnt_q;
  logic                ovf_q;

  logic [RootW-1:0] l2_ref_q, l2_test_q, l2_delta_q;
  logic [AbsW-1:0]  l1_ref_q, l1_test_q, l1_delta_q;
  logic             ref_zero_q, cnt_ovf_q;

  logic signed [SAMPLE_BITS-1:0] r_s, t_s;
  logic signed [SAMPLE_BITS:0]   d_s;
  logic [SAMPLE_BITS-1:0]        ar, at;
  logic [SAMPLE_BITS:0]          ad;

  assign r_s = in_i.ref_sample[SAMPLE_BITS-1:0];
  assign t_s = in_i.test_sample[SAMPLE_BITS-1:0];
  assign d_s = {r_s[SAMPLE_BITS-1], r_s} - {t_s[SAMPLE_BITS-1], t_s};
  assign ar  = r_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_s) : SAMPLE_BITS'(r_s);
  assign at  = t_s[SAMPLE_BITS-1] ? SAMPLE_BITS'(-t_s) : SAMPLE_BITS'(t_s);
  assign ad  = d_s[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-d_s) : (SAMPLE_BITS+1)'(d_s);

  // three roots share one bit-pair iteration each, run in parallel
  logic [SqDeltaW-1:0] rx_q [3];
  logic [SqDeltaW-1:0] rr_q [3];
  logic [SqDeltaW-1:0] rbit_q;
  logic                root_busy_q;

  // two restoring dividers run in parallel
  logic [NumW-1:0]  dnum_q [2];
  logic [AbsW-1:0]  dden_q [2];
  logic [AbsW:0]    drem_q [2];
  logic [QuotW-1:0] dquo_q [2];
  logic [5:0]       dcnt_q;
  logic             div_busy_q;

  logic [AbsW:0] rem_sh [2];
  logic [SqDeltaW-1:0] rsum [3];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {drem_q[i][AbsW-1:0], dnum_q[i][NumW-1]};
    end
    for (int i = 0; i < 3; i++) begin
      rsum[i] = rr_q[i] + rbit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_ref_q    <= '0;
      sq_test_q   <= '0;
      sq_delta_q  <= '0;
      ab_ref_q    <= '0;
      ab_test_q   <= '0;
      ab_delta_q  <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      root_busy_q <= 1'b0;
      div_busy_q  <= 1'b0;
      rbit_q      <= '0;
      dcnt_q      <= '0;
      l2_ref_q    <= '0;
      l2_test_q   <= '0;
      l2_delta_q  <= '0;
      l1_ref_q    <= '0;
      l1_test_q   <= '0;
      l1_delta_q  <= '0;
      ref_zero_q  <= 1'b0;
      cnt_ovf_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rx_q[i] <= '0;
        rr_q[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        dnum_q[i] <= '0;
        dden_q[i] <= '0;
        drem_q[i] <= '0;
        dquo_q[i] <= '0;
      end
    end else begin
      unique case (cmd_i)
        CMD_ACCUM: begin
          if (cnt_q < CntW'(COUNT_MAX)) begin
            sq_ref_q   <= sq_ref_q + SqRefW'(ar * ar);
            sq_test_q  <= sq_test_q + SqRefW'(at * at);
            sq_delta_q <= sq_delta_q + SqDeltaW'(ad * ad);
            ab_ref_q   <= ab_ref_q + AbsW'(ar);
            ab_test_q  <= ab_test_q + AbsW'(at);
            ab_delta_q <= ab_delta_q + AbsW'(ad);
            cnt_q      <= cnt_q + 1'b1;
          end else begin
            ovf_q <= 1'b1;
          end
        end
        CMD_ROOT_START: begin
          rx_q[0]     <= SqDeltaW'(sq_ref_q);
          rx_q[1]     <= SqDeltaW'(sq_test_q);
          rx_q[2]     <= sq_delta_q;
          for (int i = 0; i < 3; i++) rr_q[i] <= '0;
          rbit_q      <= SqDeltaW'(1) << (SqDeltaW - 2);
          root_busy_q <= 1'b1;
          l1_ref_q    <= ab_ref_q;
          l1_test_q   <= ab_test_q;
          l1_delta_q  <= ab_delta_q;
          ref_zero_q  <= (ab_ref_q == '0);
          cnt_ovf_q   <= ovf_q;
          sq_ref_q   <= '0;
          sq_test_q  <= '0;
          sq_delta_q <= '0;
          ab_ref_q   <= '0;
          ab_test_q  <= '0;
          ab_delta_q <= '0;
          cnt_q      <= '0;
          ovf_q      <= 1'b0;
        end
        CMD_DIV_START: begin
          dnum_q[0]  <= NumW'(rr_q[2][RootW-1:0]) << 16;
          dden_q[0]  <= AbsW'(rr_q[0][RootW-1:0]);
          dnum_q[1]  <= NumW'(l1_delta_q) << 16;
          dden_q[1]  <= l1_ref_q;
          for (int i = 0; i < 2; i++) begin
            drem_q[i] <= '0;
            dquo_q[i] <= '0;
          end
          dcnt_q     <= 6'(NumW);
          div_busy_q <= 1'b1;
          l2_ref_q   <= rr_q[0][RootW-1:0];
          l2_test_q  <= rr_q[1][RootW-1:0];
          l2_delta_q <= rr_q[2][RootW-1:0];
        end
        default: ;
      endcase

      if (root_busy_q) begin
        for (int i = 0; i < 3; i++) begin
          if (rx_q[i] >= rsum[i]) begin
            rx_q[i] <= rx_q[i] - rsum[i];
            rr_q[i] <= (rr_q[i] >> 1) + rbit_q;
          end else begin
            rr_q[i] <= rr_q[i] >> 1;
          end
        end
        rbit_q <= rbit_q >> 2;
        if (rbit_q == SqDeltaW'(1)) root_busy_q <= 1'b0;
      end

      if (div_busy_q) begin
        for (int i = 0; i < 2; i++) begin
          dnum_q[i] <= dnum_q[i] << 1;
          if (rem_sh[i] >= {1'b0, dden_q[i]}) begin
            drem_q[i] <= rem_sh[i] - {1'b0, dden_q[i]};
            dquo_q[i] <= {dquo_q[i][QuotW-2:0], 1'b1};
          end else begin
            drem_q[i] <= rem_sh[i];
            dquo_q[i] <= {dquo_q[i][QuotW-2:0], 1'b0};
          end
        end
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == 6'd1) div_busy_q <= 1'b0;
      end
    end
  end

  logic [RelW-1:0] rel [2];
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (dden_q[i] == '0 || dquo_q[i] > QuotW'({RelW{1'b1}})) rel[i] = '1;
      else rel[i] = dquo_q[i][RelW-1:0];
    end
  end

  assign result_o.l2_ref         = l2_ref_q;
  assign result_o.l2_test        = l2_test_q;
  assign result_o.l2_delta       = l2_delta_q;
  assign result_o.l1_ref         = l1_ref_q;
  assign result_o.l1_test        = l1_test_q;
  assign result_o.l1_delta       = l1_delta_q;
  assign result_o.l2_relative    = rel[0];
  assign result_o.l1_relative    = ref_zero_q ? '1 : rel[1];
  assign result_o.reference_zero = ref_zero_q;
  assign result_o.count_overflow = cnt_ovf_q;
  assign status_o.root_done = !root_busy_q;
  assign status_o.div_done  = !div_busy_q;

endmodule

// File: hdl/rle_ctrl.sv
module rle_ctrl
  import rle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  rle_status_t status_i,
  output rle_cmd_e    cmd_o
);

  typedef enum logic [2:0] {
    S_ACCUM, S_ROOT_GO, S_ROOT, S_DIV_GO, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_ACCUM);

  always_comb begin
    unique case (state_q)
      S_ACCUM:   cmd_o = (in_valid_i) ? CMD_ACCUM : CMD_IDLE;
      S_ROOT_GO: cmd_o = CMD_ROOT_START;
      S_DIV_GO:  cmd_o = CMD_DIV_START;
      default:   cmd_o = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_ACCUM:   if (in_valid_i && last_i) state_q <= S_ROOT_GO;
        S_ROOT_GO: state_q <= S_ROOT;
        S_ROOT:    if (status_i.root_done) state_q <= S_DIV_GO;
        S_DIV_GO:  state_q <= S_DIV;
        S_DIV: begin
          if (status_i.div_done) begin
            state_q     <= S_OUT;
            out_valid_o <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_ACCUM;
            out_valid_o <= 1'b0;
          end
        end
        default: state_q <= S_ACCUM;
      endcase
    end
  end

endmodule

// File: hdl/relative_l2_l1_error.sv
// Relative L2/L1 error accumulator. Each request carries a reference and a
// test sample; they are accumulated at one request per cycle. On the request
// marked last the block computes three 26-step integer square roots and
// then two 52-step restoring divisions, then holds the result until taken.
// Input is not accepted during that time.
module relative_l2_l1_error
  import rle_pkg::*;
#(
  parameter int unsigned COUNT_MAX   = 1048576,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rle_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rle_out_t out_data_o
);

  rle_cmd_e    cmd;
  rle_status_t status;

  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .last_i     (in_data_i.last_sample),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rle_datapath #(
    .COUNT_MAX  (COUNT_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .in_i    (in_data_i),
    .status_o(status),
    .result_o(out_data_o)
  );

endmodule
